// File: sv/rpti_pkg.sv
package rpti_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 64;
  localparam int DIGIT_W = 5;

  // APB register map: one register, word aligned
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_NUMBER_BASE = 1'b0;   // paddr[2] of number_base

  localparam logic [BASE_W-1:0] NUMBER_BASE_RST = 6'd10;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_AMP     = 8'h26;
  localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F    = 8'h46;

  // Bases selected by prefixes
  localparam logic [BASE_W-1:0] BASE_BIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX = 5'd9;
  localparam logic [DIGIT_W-1:0] NOT_HEX       = 5'd16;

  // Scan position within a word
  typedef enum logic [5:0] {
    SCAN_PFX_BIN = 6'b000001,  // any prefix allowed
    SCAN_PFX_OCT = 6'b000010,  // '&', '#', '$' or '-'
    SCAN_PFX_DEC = 6'b000100,  // '#', '$' or '-'
    SCAN_PFX_HEX = 6'b001000,  // '$' or '-'
    SCAN_SIGN    = 6'b010000,  // '-' only
    SCAN_DIGITS  = 6'b100000
  } scan_stage_t;

  // Per-word control state
  typedef struct packed {
    scan_stage_t         stage;
    logic [BASE_W-1:0]   base;
    logic                neg;
    logic                sat;
    logic                stopped;
    logic                valid;
  } word_state_t;

  // Hex digit value, NOT_HEX for anything else
  function automatic logic [DIGIT_W-1:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    logic [DIGIT_W-1:0] d;
    begin
      off = '0;
      d   = NOT_HEX;
      case (c) inside
        [CH_0:CH_9]: begin
          off = c - CH_0;
          d   = off[DIGIT_W-1:0];
        end
        [CH_LC_A:CH_LC_F]: begin
          off = c - CH_LC_A + 8'd10;
          d   = off[DIGIT_W-1:0];
        end
        [CH_UC_A:CH_UC_F]: begin
          off = c - CH_UC_A + 8'd10;
          d   = off[DIGIT_W-1:0];
        end
        default: d = NOT_HEX;
      endcase
      return d;
    end
  endfunction

endpackage

// File: sv/radix_prefixed_text_to_integer_unit.sv
// Flow: a terminating zero byte is held in the input register and then stepped into the
//   result register, which raises out_valid until the result is taken.
// Throughput: one character per cycle; the 64x6 multiply-add and limit compare in the
//   step logic close the per-character state loop combinationally. A zero byte waits
//   in the input register only while the previous result is still held.
// Reset (rst, synchronous, active high): clears both valid flags and the word state,
//   number_base returns to 10.
module radix_prefixed_text_to_integer_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpti_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rpti_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rpti_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // Character input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rpti_pkg::CHAR_W-1:0]       char_code,
  // Result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rpti_pkg::VALUE_W-1:0] value,
  output logic                              is_number
);

  localparam logic [VALUE_BITS-1:0] SAT_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] SAT_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [rpti_pkg::BASE_W-1:0] number_base;
  logic                        cfg_wr;

  logic                        s1_valid;
  logic [rpti_pkg::CHAR_W-1:0] s1_char;
  logic                        s1_fire, s1_end, out_free;

  rpti_pkg::word_state_t       st, st_next, st_clear;
  logic [VALUE_BITS-1:0]       mag, mag_next;
  logic signed [VALUE_BITS-1:0] res;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rpti_pkg::REG_NUMBER_BASE);
  assign prdata = (paddr[2] == rpti_pkg::REG_NUMBER_BASE) ?
                  rpti_pkg::APB_DATA_W'(number_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= rpti_pkg::NUMBER_BASE_RST;
    end else if (cfg_wr) begin
      number_base <= pwdata[rpti_pkg::BASE_W-1:0];
    end
  end

  // Handshake: an end-of-word item waits only for a free result register
  assign out_free = !out_valid || out_ready;
  assign s1_end   = (s1_char == rpti_pkg::CH_NUL);
  assign s1_fire  = s1_valid && (!s1_end || out_free);
  assign in_ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && in_ready) || (s1_valid && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= char_code;
    end
  end

  // Character step
  rpti_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .char_code   (s1_char),
    .number_base (number_base),
    .st          (st),
    .mag         (mag),
    .st_next     (st_next),
    .mag_next    (mag_next)
  );

  // Word state, cleared by reset and after each zero byte
  always_comb begin
    st_clear         = '0;
    st_clear.stage   = rpti_pkg::SCAN_PFX_BIN;
    st_clear.base    = number_base;
    st_clear.valid   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= st_clear;
      mag <= '0;
    end else if (s1_fire) begin
      if (s1_end) begin
        st  <= st_clear;
        mag <= '0;
      end else begin
        st  <= st_next;
        mag <= mag_next;
      end
    end
  end

  // Final value in VALUE_BITS, sign extended on output
  always_comb begin
    if (!st.valid) begin
      res = '0;
    end else if (st.sat) begin
      res = st.neg ? SAT_NEG : SAT_POS;
    end else begin
      res = st.neg ? (~mag + VALUE_BITS'(1)) : mag;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      value     <= rpti_pkg::VALUE_W'(res);
      is_number <= st.valid;
    end
  end

endmodule

// File: sv/rpti_step.sv
// One character step of the word scanner: prefix, sign and digit handling
module rpti_step #(
  parameter int VALUE_BITS = 64
) (
  input  logic [rpti_pkg::CHAR_W-1:0] char_code,
  input  logic [rpti_pkg::BASE_W-1:0] number_base,
  input  rpti_pkg::word_state_t       st,
  input  logic [VALUE_BITS-1:0]       mag,
  output rpti_pkg::word_state_t       st_next,
  output logic [VALUE_BITS-1:0]       mag_next
);

  localparam int PROD_W = VALUE_BITS + rpti_pkg::BASE_W;
  localparam logic [PROD_W-1:0] MAG_MAX = PROD_W'(1) << (VALUE_BITS - 1);

  logic [rpti_pkg::BASE_W-1:0]  base_cur;
  logic [rpti_pkg::DIGIT_W-1:0] digit;
  logic                         early0, early1, early2, early3, early4;
  logic                         pass, base_ok;
  logic [PROD_W-1:0]            prod, limit;

  // Base is taken from the register at the first character of a word
  assign base_cur = (st.stage == rpti_pkg::SCAN_PFX_BIN) ? number_base : st.base;

  // Which prefixes are still allowed
  assign early0 = (st.stage == rpti_pkg::SCAN_PFX_BIN);
  assign early1 = early0 || (st.stage == rpti_pkg::SCAN_PFX_OCT);
  assign early2 = early1 || (st.stage == rpti_pkg::SCAN_PFX_DEC);
  assign early3 = early2 || (st.stage == rpti_pkg::SCAN_PFX_HEX);
  assign early4 = early3 || (st.stage == rpti_pkg::SCAN_SIGN);

  // Digit checks
  assign digit   = rpti_pkg::hex_digit(char_code);
  assign pass    = (base_cur <= rpti_pkg::BASE_DEC) ? (digit <= rpti_pkg::DIGIT_DEC_MAX)
                                                    : (digit != rpti_pkg::NOT_HEX);
  assign base_ok = (base_cur >= rpti_pkg::BASE_BIN) && (base_cur <= rpti_pkg::BASE_MAX) &&
                   (rpti_pkg::BASE_W'(digit) < base_cur);

  // Multiply-add in a wider word; overflow when it passes the limit
  assign prod  = PROD_W'(mag) * PROD_W'(base_cur) + PROD_W'(digit);
  assign limit = MAG_MAX - PROD_W'(!st.neg);

  always_comb begin
    st_next      = st;
    st_next.base = base_cur;
    mag_next     = mag;
    if (early0 && char_code == rpti_pkg::CH_PERCENT) begin
      st_next.base  = rpti_pkg::BASE_BIN;
      st_next.stage = rpti_pkg::SCAN_PFX_OCT;
    end else if (early1 && char_code == rpti_pkg::CH_AMP) begin
      st_next.base  = rpti_pkg::BASE_OCT;
      st_next.stage = rpti_pkg::SCAN_PFX_DEC;
    end else if (early2 && char_code == rpti_pkg::CH_HASH) begin
      st_next.base  = rpti_pkg::BASE_DEC;
      st_next.stage = rpti_pkg::SCAN_PFX_HEX;
    end else if (early3 && char_code == rpti_pkg::CH_DOLLAR) begin
      st_next.base  = rpti_pkg::BASE_HEX;
      st_next.stage = rpti_pkg::SCAN_SIGN;
    end else if (early4 && char_code == rpti_pkg::CH_MINUS) begin
      st_next.neg   = 1'b1;
      st_next.stage = rpti_pkg::SCAN_DIGITS;
    end else begin
      st_next.stage = rpti_pkg::SCAN_DIGITS;
      if (!pass) begin
        st_next.valid = 1'b0;
      end else if (st.stopped || st.sat) begin
        // conversion over, only validity is tracked
      end else if (!base_ok) begin
        st_next.stopped = 1'b1;
      end else if (prod > limit) begin
        st_next.sat = 1'b1;
      end else begin
        mag_next = prod[VALUE_BITS-1:0];
      end
    end
  end

endmodule

// File: sv/rpti_checker.sv
// Port-level checks for the converter
module rpti_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               pready,
  input logic [rpti_pkg::APB_DATA_W-1:0]    prdata,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rpti_pkg::VALUE_W-1:0] value,
  input logic                               is_number
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(is_number))
    else $error("result changed while stalled");

  // Invalid words read as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_number |-> value == '0)
    else $error("invalid word with nonzero value");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Register readback carries only the base field
  a_prdata_range: assert property (@(posedge clk) disable iff (rst)
    pready && prdata[rpti_pkg::APB_DATA_W-1:rpti_pkg::BASE_W] == '0)
    else $error("readback out of range");

endmodule

bind radix_prefixed_text_to_integer_unit rpti_checker u_rpti_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .prdata    (prdata),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .is_number (is_number)
);

// File: verif/tb_radix_prefixed_text_to_integer_unit.sv
module tb_radix_prefixed_text_to_integer_unit;

  // Converted word as seen on the result port
  typedef struct packed {
    logic [rpti_pkg::VALUE_W-1:0] value;
    logic                         is_num;
  } conv_result_t;

  // Running value of a word and the words still to be answered
  class text_value_scoreboard;
    // how far the prefix scan has come; a prefix of lower rank is a digit afterwards
    localparam int SEEN_NONE = 0;
    localparam int SEEN_BIN  = 1;
    localparam int SEEN_OCT  = 2;
    localparam int SEEN_DEC  = 3;
    localparam int SEEN_HEX  = 4;
    localparam int IN_DIGITS = 5;

    logic [rpti_pkg::BASE_W-1:0]  base_reg;
    logic [rpti_pkg::BASE_W-1:0]  word_base;
    int                           stage;
    bit                           neg;
    bit                           sat;
    bit                           stopped;
    bit                           ok;
    logic [rpti_pkg::VALUE_W-1:0] mag;
    conv_result_t                 expected_q[$];
    int                           errors;

    function new();
      base_reg = rpti_pkg::NUMBER_BASE_RST;
      errors   = 0;
      clear_word();
    endfunction

    function void clear_word();
      stage     = SEEN_NONE;
      word_base = base_reg;
      neg       = 0;
      mag       = '0;
      sat       = 0;
      stopped   = 0;
      ok        = 1;
    endfunction

    function void set_base(logic [rpti_pkg::APB_DATA_W-1:0] v);
      base_reg = v[rpti_pkg::BASE_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // 0..15 for a hex digit of either case, 99 otherwise
    function int digit_of(logic [rpti_pkg::CHAR_W-1:0] c);
      if (c >= rpti_pkg::CH_0 && c <= rpti_pkg::CH_9) return int'(c - rpti_pkg::CH_0);
      if (c >= rpti_pkg::CH_LC_A && c <= rpti_pkg::CH_LC_F)
        return int'(c - rpti_pkg::CH_LC_A) + 10;
      if (c >= rpti_pkg::CH_UC_A && c <= rpti_pkg::CH_UC_F)
        return int'(c - rpti_pkg::CH_UC_A) + 10;
      return 99;
    endfunction

    function void take_digit(logic [rpti_pkg::CHAR_W-1:0] c);
      int d;
      logic [rpti_pkg::VALUE_W-1:0] limit;
      logic [rpti_pkg::VALUE_W-1:0] wide_base;
      d = digit_of(c);
      // digit check: decimal up to base 10, hex above
      if ((word_base <= rpti_pkg::BASE_DEC) ? (d > 9) : (d > 15)) begin
        ok = 0;
        return;
      end
      if (stopped || sat) return;
      if (word_base < rpti_pkg::BASE_BIN || word_base > rpti_pkg::BASE_MAX ||
          d >= int'(word_base)) begin
        stopped = 1;
        return;
      end
      limit     = {1'b1, {(rpti_pkg::VALUE_W-1){1'b0}}} - (neg ? 64'd0 : 64'd1);
      wide_base = 64'(word_base);
      if (mag > (limit - 64'(d)) / wide_base) sat = 1;
      else mag = mag * wide_base + 64'(d);
    endfunction

    // accepted character; a zero byte closes the word and queues its value
    function void note_char(logic [rpti_pkg::CHAR_W-1:0] c);
      conv_result_t r;
      if (c == rpti_pkg::CH_NUL) begin
        if (!ok) r.value = '0;
        else if (sat) r.value = neg ? {1'b1, {(rpti_pkg::VALUE_W-1){1'b0}}}
                                    : {1'b0, {(rpti_pkg::VALUE_W-1){1'b1}}};
        else r.value = neg ? -mag : mag;
        r.is_num = ok;
        expected_q.push_back(r);
        clear_word();
        return;
      end
      if (stage == SEEN_NONE) word_base = base_reg;
      if (stage <= SEEN_NONE && c == rpti_pkg::CH_PERCENT) begin
        word_base = rpti_pkg::BASE_BIN;
        stage     = SEEN_BIN;
      end else if (stage <= SEEN_BIN && c == rpti_pkg::CH_AMP) begin
        word_base = rpti_pkg::BASE_OCT;
        stage     = SEEN_OCT;
      end else if (stage <= SEEN_OCT && c == rpti_pkg::CH_HASH) begin
        word_base = rpti_pkg::BASE_DEC;
        stage     = SEEN_DEC;
      end else if (stage <= SEEN_DEC && c == rpti_pkg::CH_DOLLAR) begin
        word_base = rpti_pkg::BASE_HEX;
        stage     = SEEN_HEX;
      end else if (stage <= SEEN_HEX && c == rpti_pkg::CH_MINUS) begin
        neg   = 1;
        stage = IN_DIGITS;
      end else begin
        stage = IN_DIGITS;
        take_digit(c);
      end
    endfunction

    task report_mismatch(string what, logic [rpti_pkg::VALUE_W-1:0] got,
                         logic [rpti_pkg::VALUE_W-1:0] want);
      errors++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, $signed(got), $signed(want));
    endtask

    task check_result(logic [rpti_pkg::VALUE_W-1:0] v, logic num);
      conv_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no word pending", v, '0);
        return;
      end
      r = expected_q.pop_front();
      if (v !== r.value) report_mismatch("value", v, r.value);
      if (num !== r.is_num) report_mismatch("is_number", 64'(num), 64'(r.is_num));
    endtask

    task drain_leftover();
      conv_result_t r;
      while (expected_q.size() != 0) begin
        r = expected_q.pop_front();
        report_mismatch("result never arrived", '0, r.value);
      end
    endtask
  endclass

  localparam logic [rpti_pkg::APB_ADDR_W-1:0] NUMBER_BASE_ADDR =
    {rpti_pkg::REG_NUMBER_BASE, 2'b00};
  localparam logic [rpti_pkg::CHAR_W-1:0] MARKS [5] = '{rpti_pkg::CH_PERCENT,
    rpti_pkg::CH_AMP, rpti_pkg::CH_HASH, rpti_pkg::CH_DOLLAR, rpti_pkg::CH_MINUS};
  // bases per random phase: both ends of the legal range, out-of-range values, prefix bases
  localparam int PHASE_BASES [9] = '{2, 36, 16, 0, 63, 8, 1, 37, 10};
  localparam int PHASE_CHARS = 130;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [rpti_pkg::APB_ADDR_W-1:0]   paddr = '0;
  logic [rpti_pkg::APB_DATA_W-1:0]   pwdata = '0;
  logic [rpti_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [rpti_pkg::CHAR_W-1:0]       char_code = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [rpti_pkg::VALUE_W-1:0] value;
  logic                              is_number;

  int                                cycle_cnt = 0;
  logic                              calm;
  logic [rpti_pkg::CHAR_W-1:0]       word_q[$];
  text_value_scoreboard              sb = new();

  radix_prefixed_text_to_integer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .is_number (is_number)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // no idling on either side inside this window
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end
  assign calm = (cycle_cnt >= 1000) && (cycle_cnt < 1600);

  // result side: check each accepted item, then pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, is_number);
    out_ready <= calm || ($urandom_range(0, 99) >= 31);
  end

  // one character item, with random idle cycles ahead of it
  task automatic send_char(logic [rpti_pkg::CHAR_W-1:0] c);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(rpti_pkg::CH_NUL);
  endtask

  // write number_base with junk in the upper bits, then read it back
  task automatic apb_set_base(logic [rpti_pkg::BASE_W-1:0] base);
    logic [rpti_pkg::APB_DATA_W-1:0] word;
    word    = ($urandom() & ~32'h3F) | 32'(base);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= NUMBER_BASE_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_base(word);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(base)) sb.report_mismatch("number_base readback", 64'(prdata), 64'(base));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold input, wait for all results and for any character still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random word: mostly well formed for the base it will use, some broken, some noise
  function automatic void make_word(logic [rpti_pkg::BASE_W-1:0] cfg);
    int kind;
    int n;
    int d;
    int top;
    int lim;
    logic [rpti_pkg::BASE_W-1:0] eff;
    logic [rpti_pkg::CHAR_W-1:0] junk;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      n = $urandom_range(1, 8);
      repeat (n) word_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      eff = cfg;
      if ($urandom_range(0, 3) == 0) begin
        word_q.push_back(rpti_pkg::CH_PERCENT);
        eff = rpti_pkg::BASE_BIN;
      end
      if ($urandom_range(0, 3) == 0) begin
        word_q.push_back(rpti_pkg::CH_AMP);
        eff = rpti_pkg::BASE_OCT;
      end
      if ($urandom_range(0, 3) == 0) begin
        word_q.push_back(rpti_pkg::CH_HASH);
        eff = rpti_pkg::BASE_DEC;
      end
      if ($urandom_range(0, 3) == 0) begin
        word_q.push_back(rpti_pkg::CH_DOLLAR);
        eff = rpti_pkg::BASE_HEX;
      end
      if ($urandom_range(0, 3) == 0) word_q.push_back(rpti_pkg::CH_MINUS);
      // long runs push toward saturation
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 66) : $urandom_range(0, 10);
      top = (eff <= rpti_pkg::BASE_DEC) ? 9 : 15;
      lim = (int'(eff) < top + 1) ? int'(eff) : top + 1;
      repeat (n) begin
        d = $urandom_range(0, top);
        if (eff >= rpti_pkg::BASE_BIN && eff <= rpti_pkg::BASE_MAX &&
            $urandom_range(0, 9) != 0)
          d = $urandom_range(0, lim - 1);
        if (d < 10) word_q.push_back(rpti_pkg::CH_0 + 8'(d));
        else word_q.push_back(($urandom_range(0, 1) ? rpti_pkg::CH_LC_A : rpti_pkg::CH_UC_A)
                              + 8'(d - 10));
      end
      if (kind >= 70) begin
        case ($urandom_range(0, 1))
          0: junk = 8'($urandom_range(1, 255));
          default: junk = MARKS[$urandom_range(0, 4)];
        endcase
        if (word_q.size() == 0) word_q.push_back(junk);
        else word_q[$urandom_range(0, word_q.size() - 1)] = junk;
      end
    end
    word_q.push_back(rpti_pkg::CH_NUL);
  endfunction

  initial begin
    int guard;
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset base
    send_text("");
    send_text("-");
    send_text("%&#$-fF");
    send_text("&19");
    send_text("-%1");
    send_text("9223372036854775808");
    send_text("$7FFFFFFFFFFFFFFF");
    send_text("$-8000000000000000");
    send_char(8'hFF);
    send_char(rpti_pkg::CH_NUL);

    // random phases; odd phases stop inside a word so the write lands mid-word
    foreach (PHASE_BASES[p]) begin
      wait_idle();
      apb_set_base(PHASE_BASES[p][rpti_pkg::BASE_W-1:0]);
      sent = 0;
      while (sent < PHASE_CHARS) begin
        if (word_q.size() == 0) make_word(PHASE_BASES[p][rpti_pkg::BASE_W-1:0]);
        send_char(word_q.pop_front());
        sent++;
      end
      if (p % 2 == 0 || p == $size(PHASE_BASES) - 1) begin
        while (word_q.size() != 0) send_char(word_q.pop_front());
      end
    end

    // drain
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    sb.drain_leftover();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: radix_prefixed_text_to_integer_unit.f
sv/rpti_pkg.sv
sv/rpti_step.sv
sv/radix_prefixed_text_to_integer_unit.sv
sv/rpti_checker.sv
verif/tb_radix_prefixed_text_to_integer_unit.sv
